// ===== hdl/ecct_pkg.sv =====
// shared constants, types and tables for the epoch seconds to civil time converter
`default_nettype none
package ecct_pkg;

   localparam int ECCT_STAGES = 9;

   // seconds from 1600-03-01 to 1970-01-01, keeps the shifted count positive
   localparam logic [33:0] DAY_BIAS_SEC = 34'd11670912000;

   // reciprocals for constant division, exact over the operand ranges used
   localparam logic [27:0] M_DAY     = 28'd203613265;  // 1/675 at shift 37
   localparam int          S_DAY     = 37;
   localparam logic [16:0] SEC_DAY   = 17'd86400;
   localparam logic [17:0] DAYS_ERA  = 18'd146097;
   localparam logic [17:0] M_HOUR    = 18'd149131;     // 1/3600 at shift 29
   localparam logic [11:0] SEC_HOUR  = 12'd3600;
   localparam logic [12:0] M_MIN     = 13'd4370;       // 1/60 at shift 18
   localparam logic [18:0] M_1460    = 19'd367720;     // 1/1460 at shift 29
   localparam logic [18:0] M_365     = 19'd367720;     // 1/365 at shift 27
   localparam logic [11:0] M_153     = 12'd3427;       // 1/153 at shift 19

   localparam logic [17:0] DAYS_CENT  = 18'd36524;
   localparam logic [17:0] DAYS_ERA_M = 18'd146096;

   localparam logic [10:0] YEAR_BASE = 11'd1600;
   localparam logic [10:0] ERA_YEARS = 11'd400;

   typedef struct packed {
      logic [ECCT_STAGES-1:0] load;
   } ecct_adv_type;

   // first day of each month counted from march
   function automatic logic [8:0] month_start(input logic [3:0] mp);
      logic [8:0] r;
      unique case (mp)
         4'd0:    r = 9'd0;
         4'd1:    r = 9'd31;
         4'd2:    r = 9'd61;
         4'd3:    r = 9'd92;
         4'd4:    r = 9'd122;
         4'd5:    r = 9'd153;
         4'd6:    r = 9'd184;
         4'd7:    r = 9'd214;
         4'd8:    r = 9'd245;
         4'd9:    r = 9'd275;
         4'd10:   r = 9'd306;
         4'd11:   r = 9'd337;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/ecct_datapath.sv =====
// pipelined arithmetic from epoch seconds and offset to date and time of day
`default_nettype none
module ecct_datapath (
   input  logic                 clock,
   input  ecct_pkg::ecct_adv_type adv,
   input  logic [31:0]          in_utc_seconds,
   input  logic [16:0]          in_offset,
   output logic [10:0]          out_year,
   output logic [3:0]           out_month,
   output logic [4:0]           out_day,
   output logic [4:0]           out_hour,
   output logic [5:0]           out_minute,
   output logic [5:0]           out_second
);
   import ecct_pkg::*;

   // stage 0: shifted seconds
   logic [33:0] s0_u_ff, s0_u_in;
   // stage 1: day number
   logic [54:0] s1_prod;
   logic [17:0] s1_z_ff, s1_z_in;
   logic [16:0] s1_ulo_ff;
   // stage 2: time of day, day of era
   logic [34:0] s2_zsec;
   logic [16:0] s2_rem_ff, s2_rem_in;
   logic [17:0] s2_doe_ff, s2_doe_in;
   logic        s2_era_ff, s2_era_in;
   // stage 3
   logic [34:0] s3_hprod;
   logic [36:0] s3_nprod;
   logic [4:0]  s3_hour_ff;
   logic [6:0]  s3_n1460_ff;
   logic [2:0]  s3_ncent_ff, s3_ncent_in;
   logic        s3_last_ff;
   logic [16:0] s3_rem_ff;
   logic [17:0] s3_doe_ff;
   logic        s3_era_ff;
   // stage 4
   logic [16:0] s4_hsec;
   logic [11:0] s4_r2_ff, s4_r2_in;
   logic [17:0] s4_ynum_ff, s4_ynum_in;
   logic [4:0]  s4_hour_ff;
   logic [17:0] s4_doe_ff;
   logic        s4_era_ff;
   // stage 5
   logic [24:0] s5_mprod;
   logic [36:0] s5_yprod;
   logic [5:0]  s5_min_ff;
   logic [8:0]  s5_yoe_ff;
   logic [11:0] s5_r2_ff;
   logic [4:0]  s5_hour_ff;
   logic [17:0] s5_doe_ff;
   logic        s5_era_ff;
   // stage 6
   logic [11:0] s6_msec;
   logic [1:0]  s6_ycent;
   logic [17:0] s6_ystart;
   logic [17:0] s6_doy_full;
   logic [5:0]  s6_sec_ff, s6_sec_in;
   logic [8:0]  s6_doy_ff;
   logic [8:0]  s6_yoe_ff;
   logic [5:0]  s6_min_ff;
   logic [4:0]  s6_hour_ff;
   logic        s6_era_ff;
   // stage 7
   logic [10:0] s7_num;
   logic [22:0] s7_pprod;
   logic [3:0]  s7_mp_ff;
   logic [8:0]  s7_doy_ff;
   logic [8:0]  s7_yoe_ff;
   logic [5:0]  s7_sec_ff;
   logic [5:0]  s7_min_ff;
   logic [4:0]  s7_hour_ff;
   logic        s7_era_ff;
   // stage 8: output
   logic [3:0]  s8_month;
   logic [10:0] s8_year_ff, s8_year_in;
   logic [3:0]  s8_month_ff;
   logic [4:0]  s8_day_ff, s8_day_in;
   logic [4:0]  s8_hour_ff;
   logic [5:0]  s8_min_ff;
   logic [5:0]  s8_sec_ff;

   assign s0_u_in = {{2{in_utc_seconds[31]}}, in_utc_seconds}
                  + {{17{in_offset[16]}}, in_offset}
                  + DAY_BIAS_SEC;

   assign s1_prod = 55'(s0_u_ff[33:7]) * 55'(M_DAY);
   assign s1_z_in = s1_prod[S_DAY+17:S_DAY];

   assign s2_zsec   = 35'(s1_z_ff) * 35'(SEC_DAY);
   assign s2_rem_in = s1_ulo_ff - s2_zsec[16:0];
   assign s2_era_in = (s1_z_ff >= DAYS_ERA);
   assign s2_doe_in = s2_era_in ? (s1_z_ff - DAYS_ERA) : s1_z_ff;

   assign s3_hprod = 35'(s2_rem_ff) * 35'(M_HOUR);
   assign s3_nprod = 37'(s2_doe_ff) * 37'(M_1460);
   assign s3_ncent_in = 3'(s2_doe_ff >= DAYS_CENT)
                      + 3'(s2_doe_ff >= 18'(2 * DAYS_CENT))
                      + 3'(s2_doe_ff >= 18'(3 * DAYS_CENT))
                      + 3'(s2_doe_ff >= DAYS_ERA_M);

   assign s4_hsec    = 17'(s3_hour_ff) * 17'(SEC_HOUR);
   assign s4_r2_in   = 12'(s3_rem_ff - s4_hsec);
   assign s4_ynum_in = s3_doe_ff - 18'(s3_n1460_ff) + 18'(s3_ncent_ff)
                     - 18'(s3_last_ff);

   assign s5_mprod = 25'(s4_r2_ff) * 25'(M_MIN);
   assign s5_yprod = 37'(s4_ynum_ff) * 37'(M_365);

   assign s6_msec  = 12'(s5_min_ff) * 12'd60;
   assign s6_sec_in = 6'(s5_r2_ff - s6_msec);
   assign s6_ycent = 2'(s5_yoe_ff >= 9'd100) + 2'(s5_yoe_ff >= 9'd200)
                   + 2'(s5_yoe_ff >= 9'd300);
   assign s6_ystart = 18'(s5_yoe_ff) * 18'd365 + 18'(s5_yoe_ff[8:2]) - 18'(s6_ycent);
   assign s6_doy_full = s5_doe_ff - s6_ystart;

   assign s7_num   = 11'(s6_doy_ff) * 11'd5 + 11'd2;
   assign s7_pprod = 23'(s7_num) * 23'(M_153);

   assign s8_month   = (s7_mp_ff < 4'd10) ? (s7_mp_ff + 4'd3) : (s7_mp_ff - 4'd9);
   assign s8_day_in  = 5'(s7_doy_ff - month_start(s7_mp_ff) + 9'd1);
   assign s8_year_in = YEAR_BASE + (s7_era_ff ? ERA_YEARS : 11'd0) + 11'(s7_yoe_ff)
                     + 11'(s8_month <= 4'd2);

   always_ff @(posedge clock) begin
      if (adv.load[0]) begin
         s0_u_ff <= s0_u_in;
      end
      if (adv.load[1]) begin
         s1_z_ff   <= s1_z_in;
         s1_ulo_ff <= s0_u_ff[16:0];
      end
      if (adv.load[2]) begin
         s2_rem_ff <= s2_rem_in;
         s2_doe_ff <= s2_doe_in;
         s2_era_ff <= s2_era_in;
      end
      if (adv.load[3]) begin
         s3_hour_ff  <= s3_hprod[33:29];
         s3_n1460_ff <= s3_nprod[35:29];
         s3_ncent_ff <= s3_ncent_in;
         s3_last_ff  <= (s2_doe_ff == DAYS_ERA_M);
         s3_rem_ff   <= s2_rem_ff;
         s3_doe_ff   <= s2_doe_ff;
         s3_era_ff   <= s2_era_ff;
      end
      if (adv.load[4]) begin
         s4_r2_ff   <= s4_r2_in;
         s4_ynum_ff <= s4_ynum_in;
         s4_hour_ff <= s3_hour_ff;
         s4_doe_ff  <= s3_doe_ff;
         s4_era_ff  <= s3_era_ff;
      end
      if (adv.load[5]) begin
         s5_min_ff  <= s5_mprod[23:18];
         s5_yoe_ff  <= s5_yprod[35:27];
         s5_r2_ff   <= s4_r2_ff;
         s5_hour_ff <= s4_hour_ff;
         s5_doe_ff  <= s4_doe_ff;
         s5_era_ff  <= s4_era_ff;
      end
      if (adv.load[6]) begin
         s6_sec_ff  <= s6_sec_in;
         s6_doy_ff  <= s6_doy_full[8:0];
         s6_yoe_ff  <= s5_yoe_ff;
         s6_min_ff  <= s5_min_ff;
         s6_hour_ff <= s5_hour_ff;
         s6_era_ff  <= s5_era_ff;
      end
      if (adv.load[7]) begin
         s7_mp_ff   <= s7_pprod[22:19];
         s7_doy_ff  <= s6_doy_ff;
         s7_yoe_ff  <= s6_yoe_ff;
         s7_sec_ff  <= s6_sec_ff;
         s7_min_ff  <= s6_min_ff;
         s7_hour_ff <= s6_hour_ff;
         s7_era_ff  <= s6_era_ff;
      end
      if (adv.load[8]) begin
         s8_year_ff  <= s8_year_in;
         s8_month_ff <= s8_month;
         s8_day_ff   <= s8_day_in;
         s8_hour_ff  <= s7_hour_ff;
         s8_min_ff   <= s7_min_ff;
         s8_sec_ff   <= s7_sec_ff;
      end
   end

   assign out_year   = s8_year_ff;
   assign out_month  = s8_month_ff;
   assign out_day    = s8_day_ff;
   assign out_hour   = s8_hour_ff;
   assign out_minute = s8_min_ff;
   assign out_second = s8_sec_ff;

endmodule
`default_nettype wire

// ===== hdl/epoch_seconds_to_civil_time_top.sv =====
// top level of the epoch seconds to civil time converter: offset register and stage control
//
//  channel | ports                          | direction
//  --------+--------------------------------+----------
//  req     | req_valid req_ready req_*      | in
//  rsp     | rsp_valid rsp_ready rsp_*      | out
//  csr     | csr_wr_en csr_wr_data          | in
//
// nine register stages, one transfer per cycle sustained while rsp_ready stays high
// the multiply stages (day, hour, minute, year, month reciprocals) set the depth
// reset clears the valid bits and sets the offset to zero
// a stalled result holds; earlier stages keep filling empty slots behind it
`default_nettype none
module epoch_seconds_to_civil_time_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_utc_seconds,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [10:0]        rsp_year,
   output logic [3:0]         rsp_month,
   output logic [4:0]         rsp_day,
   output logic [4:0]         rsp_hour,
   output logic [5:0]         rsp_minute,
   output logic [5:0]         rsp_second,
   input  logic               csr_wr_en,
   input  logic signed [16:0] csr_wr_data
);
   import ecct_pkg::*;

   logic [16:0]            offset_ff, offset_in;
   logic [ECCT_STAGES-1:0] vld_ff, vld_in;
   logic [ECCT_STAGES-1:0] take;
   ecct_adv_type           adv;

   assign offset_in = csr_wr_en ? csr_wr_data : offset_ff;

   // a stage loads when empty or when the one after it moves
   always_comb begin
      take[ECCT_STAGES-1] = !vld_ff[ECCT_STAGES-1] || rsp_ready;
      for (int i = ECCT_STAGES - 2; i >= 0; i--) begin
         take[i] = !vld_ff[i] || take[i+1];
      end
      vld_in[0] = take[0] ? req_valid : vld_ff[0];
      for (int i = 1; i < ECCT_STAGES; i++) begin
         vld_in[i] = take[i] ? vld_ff[i-1] : vld_ff[i];
      end
      adv.load = take;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         vld_ff    <= '0;
      end else begin
         offset_ff <= offset_in;
         vld_ff    <= vld_in;
      end
   end

   assign req_ready = take[0];
   assign rsp_valid = vld_ff[ECCT_STAGES-1];

   ecct_datapath u_datapath (
      .clock          (clock),
      .adv            (adv),
      .in_utc_seconds (req_utc_seconds),
      .in_offset      (offset_ff),
      .out_year       (rsp_year),
      .out_month      (rsp_month),
      .out_day        (rsp_day),
      .out_hour       (rsp_hour),
      .out_minute     (rsp_minute),
      .out_second     (rsp_second)
   );

endmodule
`default_nettype wire

// ===== hdl/ecct_checker.sv =====
// port-level assertions for the converter top level, with its bind
`default_nettype none
module ecct_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [10:0]        rsp_year,
   input logic [3:0]         rsp_month,
   input logic [4:0]         rsp_day,
   input logic [4:0]         rsp_hour,
   input logic [5:0]         rsp_minute,
   input logic [5:0]         rsp_second
);
   import ecct_pkg::*;

   localparam int CW = $clog2(ECCT_STAGES + 1);

   logic [CW-1:0] count_ff, count_in;
   logic          in_xfer, out_xfer;

   assign in_xfer  = req_valid && req_ready;
   assign out_xfer = rsp_valid && rsp_ready;
   assign count_in = count_ff + CW'(in_xfer) - CW'(out_xfer);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // held result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_year) && $stable(rsp_month)
         && $stable(rsp_day) && $stable(rsp_hour) && $stable(rsp_minute)
         && $stable(rsp_second))
      else $error("result changed while stalled");

   // no result without an outstanding transfer
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> count_ff != '0)
      else $error("result with nothing in flight");

   // never more in flight than stages
   a_depth: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(ECCT_STAGES))
      else $error("more transfers in flight than stages");

   // fields stay in calendar range
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_month >= 4'd1 && rsp_month <= 4'd12 && rsp_day >= 5'd1
         && rsp_hour <= 5'd23 && rsp_minute <= 6'd59 && rsp_second <= 6'd59
         && rsp_year >= 11'd1901 && rsp_year <= 11'd2038)
      else $error("result field out of range");

   a_reset_clear: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind epoch_seconds_to_civil_time_top ecct_checker u_ecct_checker (.*);
`default_nettype wire
